// ===== hw/rtl/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// shared types, character codes and helpers for the escape decoder
// ----------------------------------------------------------------------------
package sed_pkg;

	localparam int unsigned CharW    = 8;
	localparam int unsigned CountW   = 16;
	localparam int unsigned MaxRes   = 3;
	localparam int unsigned ResNumW  = 2;

	localparam logic [CountW-1:0] CountMax = 16'hFFFF;

	// decode modes
	localparam logic [1:0] ModeNormal = 2'd0;
	localparam logic [1:0] ModeEsc    = 2'd1;
	localparam logic [1:0] ModeHexHi  = 2'd2;
	localparam logic [1:0] ModeHexLo  = 2'd3;

	// character codes
	localparam logic [CharW-1:0] ChNul   = 8'h00;
	localparam logic [CharW-1:0] ChBsl   = 8'h5C;
	localparam logic [CharW-1:0] ChX     = 8'h78;
	localparam logic [CharW-1:0] ChN     = 8'h6E;
	localparam logic [CharW-1:0] ChT     = 8'h74;
	localparam logic [CharW-1:0] ChR     = 8'h72;
	localparam logic [CharW-1:0] ChB     = 8'h62;
	localparam logic [CharW-1:0] ChF     = 8'h66;
	localparam logic [CharW-1:0] ChZero  = 8'h30;
	localparam logic [CharW-1:0] ChNine  = 8'h39;
	localparam logic [CharW-1:0] ChLoA   = 8'h61;
	localparam logic [CharW-1:0] ChLoF   = 8'h66;
	localparam logic [CharW-1:0] ChUpA   = 8'h41;
	localparam logic [CharW-1:0] ChUpF   = 8'h46;

	// control byte values
	localparam logic [CharW-1:0] ByteLf  = 8'h0A;
	localparam logic [CharW-1:0] ByteTab = 8'h09;
	localparam logic [CharW-1:0] ByteCr  = 8'h0D;
	localparam logic [CharW-1:0] ByteBs  = 8'h08;
	localparam logic [CharW-1:0] ByteFf  = 8'h0C;

	// group of results produced by one input character
	typedef struct packed {
		logic [ResNumW-1:0]              num;
		logic                            term;
		logic [MaxRes-1:0][CharW-1:0]    data;
		logic [MaxRes-1:0][CountW-1:0]   count;
	} res_group_t;

	function automatic logic is_hex(input logic [CharW-1:0] c);
		return ((c >= ChZero) && (c <= ChNine)) || ((c >= ChLoA) && (c <= ChLoF)) ||
			((c >= ChUpA) && (c <= ChUpF));
	endfunction

	function automatic logic [3:0] hex_val(input logic [CharW-1:0] c);
		logic [CharW-1:0] v;
		if ((c >= ChZero) && (c <= ChNine)) begin
			v = c - ChZero;
		end else if ((c >= ChLoA) && (c <= ChLoF)) begin
			v = c - ChLoA + 8'd10;
		end else begin
			v = c - ChUpA + 8'd10;
		end
		return v[3:0];
	endfunction

	// saturating count plus a small step
	function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] cnt,
			input logic [1:0] step);
		logic [CountW:0] s;
		s = {1'b0, cnt} + {{(CountW-1){1'b0}}, step};
		return s[CountW] ? CountMax : s[CountW-1:0];
	endfunction

endpackage

// ===== hw/rtl/sed_decode.sv =====
// ----------------------------------------------------------------------------
// sed_decode
// escape state, string count and the per-character decode
// ----------------------------------------------------------------------------
module sed_decode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [sed_pkg::CharW-1:0] char_code,
	input  logic                      take,
	output sed_pkg::res_group_t       grp
);

	logic [1:0]                 mode_q;
	logic [sed_pkg::CharW-1:0]  high_q;
	logic [sed_pkg::CountW-1:0] cnt_q;

	logic [1:0]                 mode_d;
	logic [sed_pkg::CharW-1:0]  high_d;
	logic [sed_pkg::CountW-1:0] cnt_d;
	logic [sed_pkg::CharW-1:0]  esc_byte;
	logic [sed_pkg::CountW-1:0] cnt1;
	logic [sed_pkg::CountW-1:0] cnt2;
	logic [sed_pkg::CountW-1:0] cnt3;

	assign cnt1 = sed_pkg::sat_add(cnt_q, 2'd1);
	assign cnt2 = sed_pkg::sat_add(cnt_q, 2'd2);
	assign cnt3 = sed_pkg::sat_add(cnt_q, 2'd3);

	always_comb begin
		unique case (char_code)
			sed_pkg::ChN:    esc_byte = sed_pkg::ByteLf;
			sed_pkg::ChT:    esc_byte = sed_pkg::ByteTab;
			sed_pkg::ChR:    esc_byte = sed_pkg::ByteCr;
			sed_pkg::ChB:    esc_byte = sed_pkg::ByteBs;
			sed_pkg::ChF:    esc_byte = sed_pkg::ByteFf;
			sed_pkg::ChZero: esc_byte = sed_pkg::ChNul;
			default:         esc_byte = char_code;
		endcase
	end

	always_comb begin
		grp        = '0;
		mode_d     = mode_q;
		high_d     = high_q;
		cnt_d      = cnt_q;
		if (char_code == sed_pkg::ChNul) begin
			// end of string: pending escape dropped
			grp.num      = 2'd1;
			grp.term     = 1'b1;
			grp.count[0] = cnt_q;
			mode_d       = sed_pkg::ModeNormal;
			high_d       = '0;
			cnt_d        = '0;
		end else begin
			unique case (mode_q)
				sed_pkg::ModeNormal: begin
					if (char_code == sed_pkg::ChBsl) begin
						mode_d = sed_pkg::ModeEsc;
					end else begin
						grp.num      = 2'd1;
						grp.data[0]  = char_code;
						grp.count[0] = cnt1;
						cnt_d        = cnt1;
					end
				end
				sed_pkg::ModeEsc: begin
					if (char_code == sed_pkg::ChX) begin
						mode_d = sed_pkg::ModeHexHi;
					end else begin
						mode_d       = sed_pkg::ModeNormal;
						grp.num      = 2'd1;
						grp.data[0]  = esc_byte;
						grp.count[0] = cnt1;
						cnt_d        = cnt1;
					end
				end
				sed_pkg::ModeHexHi: begin
					high_d = char_code;
					mode_d = sed_pkg::ModeHexLo;
				end
				sed_pkg::ModeHexLo: begin
					mode_d = sed_pkg::ModeNormal;
					high_d = '0;
					if (sed_pkg::is_hex(high_q) && sed_pkg::is_hex(char_code)) begin
						grp.num      = 2'd1;
						grp.data[0]  = {sed_pkg::hex_val(high_q), sed_pkg::hex_val(char_code)};
						grp.count[0] = cnt1;
						cnt_d        = cnt1;
					end else begin
						// not a hex pair: give back x and both characters
						grp.num      = 2'd3;
						grp.data[0]  = sed_pkg::ChX;
						grp.data[1]  = high_q;
						grp.data[2]  = char_code;
						grp.count[0] = cnt1;
						grp.count[1] = cnt2;
						grp.count[2] = cnt3;
						cnt_d        = cnt3;
					end
				end
				default: begin
					mode_d = sed_pkg::ModeNormal;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sed_pkg::ModeNormal;
			high_q <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			high_q <= high_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// ===== hw/rtl/sed_out_buf.sv =====
// ----------------------------------------------------------------------------
// sed_out_buf
// result register holding one group of up to three results, sent in order
// ----------------------------------------------------------------------------
module sed_out_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sed_pkg::res_group_t         grp,
	input  logic                        load,
	output logic                        free,
	output logic                        m_valid,
	input  logic                        m_ready,
	output logic [sed_pkg::CharW-1:0]   m_byte,
	output logic [sed_pkg::CountW-1:0]  m_count,
	output logic                        m_term,
	output logic                        m_last
);

	logic [sed_pkg::ResNumW-1:0]                          n_q;
	logic                                                 term_q;
	logic [sed_pkg::MaxRes-1:0][sed_pkg::CharW-1:0]       data_q;
	logic [sed_pkg::MaxRes-1:0][sed_pkg::CountW-1:0]      count_q;
	logic                                                 pop;

	assign pop     = m_valid && m_ready;
	assign free    = (n_q == '0) || ((n_q == 2'd1) && m_ready);
	assign m_valid = (n_q != '0);
	assign m_byte  = data_q[0];
	assign m_count = count_q[0];
	assign m_term  = term_q;
	assign m_last  = (n_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			term_q <= 1'b0;
		end else if (load) begin
			n_q    <= grp.num;
			term_q <= grp.term;
		end else if (pop) begin
			n_q    <= n_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q  <= grp.data;
			count_q <= grp.count;
		end else if (pop) begin
			data_q  <= {data_q[sed_pkg::MaxRes-1], data_q[sed_pkg::MaxRes-1:1]};
			count_q <= {count_q[sed_pkg::MaxRes-1], count_q[sed_pkg::MaxRes-1:1]};
		end
	end

`ifndef ASSERT_OFF
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result group loaded over pending results");
	a_term_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid && m_term) |-> (n_q == 2'd1))
		else $error("terminator result not alone in its group");
	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (grp.num != '0))
		else $error("empty result group loaded");
`endif

endmodule

// ===== hw/rtl/string_escape_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// string_escape_decoder_unit
// C-style string escape decoder, one character per transaction
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one character per transaction in tdata[7:0]; a zero
//   character ends the string and produces one terminator result
//   m_axis carries decoded bytes: tdata[7:0] byte, tdata[23:8] running count,
//   tuser marks the terminator (byte 0, count = total bytes of the string),
//   tlast marks the last result caused by one input character
// path: a character is registered in the input register, decoded, and loaded into
//   the result register once that has space; its results go out on m_axis from
//   the result register
// throughput: one character per cycle while the result register has space; a
//   "\x" with a non-hex pair gives three results, sent one per cycle from the result
//   register while m_axis_tready is high, so the input holds behind it until the last is taken
// characters that produce nothing (backslash, x, first hex character) pass
//   through without waiting on m_axis
// reset: asynchronous, clears escape state, count and both registers
// stall: with m_axis_tready low the result register holds its transaction,
//   the input register fills and s_axis_tready drops until space frees up
// ----------------------------------------------------------------------------
module string_escape_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	// result channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] byte_count
	output logic        m_axis_tuser,   // [0] is_terminator
	output logic        m_axis_tlast
);

	// input register stage
	logic                      valid_s1;
	logic [sed_pkg::CharW-1:0] char_s1;

	sed_pkg::res_group_t       grp;
	logic                      buf_free;
	logic                      take;
	logic                      load;
	logic [sed_pkg::CharW-1:0] res_byte;
	logic [sed_pkg::CountW-1:0] res_count;

	// a character leaves the input stage when its results fit the result register
	assign take          = valid_s1 && ((grp.num == '0) || buf_free);
	assign load          = take && (grp.num != '0);
	assign s_axis_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
		end
	end

	// escape decode and string state
	sed_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_s1),
		.take      (take),
		.grp       (grp)
	);

	// result register and serializer
	sed_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.grp     (grp),
		.load    (load),
		.free    (buf_free),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_byte  (res_byte),
		.m_count (res_count),
		.m_term  (m_axis_tuser),
		.m_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {res_count, res_byte};

`ifndef ASSERT_OFF
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty input register");
	a_term_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (res_byte == sed_pkg::ChNul)))
		else $error("malformed terminator result");
	a_count_after_term: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tuser) |=>
		(!m_axis_tvalid || m_axis_tuser || (res_count == 16'd1) || (res_count == 16'd3)))
		else $error("count not restarted after terminator");
`endif

endmodule
